FILE: rtl/core/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared constants and types for the sub-pixel corner refiner.
// ----------------------------------------------------------------------------
package scr_pkg;

	// command codes carried on s_tuser
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_REFINE = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_ITERS    = 2'd0;
	localparam logic [1:0] REG_EPS_SQ       = 2'd1;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

	// fixed window geometry and number format
	localparam int WIN_HALF   = 5;
	localparam int WIN_SPAN   = 2 * WIN_HALF + 1;   // 11 weighted pixels per axis
	localparam int SCAN_SPAN  = WIN_SPAN + 2;       // plus one-pixel border
	localparam int FRAC_BITS  = 8;
	localparam int COORD_W    = 18;
	localparam int ITER_W     = 7;
	localparam int ITER_CAP   = 100;
	localparam int NORM_BITS  = 22;
	localparam int MOVE_BITS  = FRAC_BITS + 13;

	// exp(-(k/5)^2) in Q1.16, k = 0..5 (center value is exactly 1.0)
	localparam logic [16:0] AXIS_WEIGHT [0:WIN_HALF] = '{
		17'd65536, 17'd62966, 17'd55846, 17'd45723, 17'd34557, 17'd24109
	};

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ITER_W-1:0]  iter_t;

endpackage

FILE: rtl/core/subpixel_corner_refiner_top.sv
// ----------------------------------------------------------------------------
// subpixel_corner_refiner_top
// Image store plus iterative gradient-based sub-pixel corner refinement.
// ----------------------------------------------------------------------------
// Operation: a pixel write goes straight into the store. Each refine iteration
//   runs a window check, a 169-pixel window scan over the single store read
//   port, a pipeline drain, normalization, the solve, two radix-2 divides and
//   the position update, for up to 100 iterations.
// Throughput: one transaction at a time; writes are taken every cycle while idle.
// Reset: control and config registers return to their defaults; the image
//   store is not cleared and holds garbage until written.
module subpixel_corner_refiner_top #(
	parameter int IMG_WIDTH  = 1024,
	parameter int IMG_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] pixel_column, [19:10] pixel_row, [27:20] pixel_value,
	// [45:28] start_x, [63:46] start_y
	input  logic [63:0] s_tdata,
	// [0] command
	input  logic        s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [17:0] refined_x, [35:18] refined_y, [42:36] iterations_done, rest zero
	output logic [47:0] m_tdata,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import scr_pkg::*;

	localparam int DEPTH   = IMG_WIDTH * IMG_HEIGHT;
	localparam int AW      = $clog2(DEPTH);
	localparam int IMG_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
	localparam int DIM_W   = ($clog2(IMG_MAX + 1) > 11) ? $clog2(IMG_MAX + 1) : 11;
	localparam int ACC_W   = 48;       // window sums, signed
	localparam int NV_W    = NORM_BITS + 1;  // normalized sums, signed
	localparam int SOL_W   = 47;       // determinant and numerators, signed
	localparam int NUM_W   = SOL_W - 1 + FRAC_BITS; // scaled numerator magnitude
	localparam int DEN_W   = SOL_W - 1;
	localparam int PW      = 24;       // working point, signed
	localparam int SCAN_LAST = SCAN_SPAN - 1;
	localparam int LINE_LEN  = 2 * SCAN_SPAN;
	localparam int K_A = 0, K_B = 1, K_C = 2, K_B1 = 3, K_B2 = 4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_SCAN, ST_DRAIN, ST_NORM, ST_PROD, ST_DIFF,
		ST_DIV_INIT, ST_DIV_RUN, ST_DIV_DONE, ST_UPDATE, ST_SQUARE, ST_TEST, ST_FINAL
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0]  max_iters_q;
	logic [15:0] eps_sq_q;
	logic [10:0] image_width_q, image_height_q;

	// image store
	logic [7:0]    mem_q [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] rd_addr_q;

	// input fields
	logic [9:0] in_col, in_row;
	logic [7:0] in_val;
	coord_t     in_sx, in_sy;
	logic       s_fire, wr_en;
	logic [AW-1:0] wr_addr;

	assign in_col = s_tdata[9:0];
	assign in_row = s_tdata[19:10];
	assign in_val = s_tdata[27:20];
	assign in_sx  = s_tdata[45:28];
	assign in_sy  = s_tdata[63:46];

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign wr_en    = s_fire && (s_tuser == CMD_WRITE) &&
	                  (DIM_W'(in_col) < DIM_W'(IMG_WIDTH)) &&
	                  (DIM_W'(in_row) < DIM_W'(IMG_HEIGHT));
	assign wr_addr  = AW'(in_row) * AW'(IMG_WIDTH) + AW'(in_col);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= in_val;
		end
		rdata_q <= mem_q[rd_addr_q];
	end

	// effective image size: min(register, store)
	logic [10:0] w_eff, h_eff;
	assign w_eff = (DIM_W'(image_width_q) < DIM_W'(IMG_WIDTH)) ? image_width_q : 11'(IMG_WIDTH);
	assign h_eff = (DIM_W'(image_height_q) < DIM_W'(IMG_HEIGHT)) ? image_height_q : 11'(IMG_HEIGHT);

	// refinement state
	coord_t         sx_q, sy_q;
	logic signed [PW-1:0] px_q, py_q;
	logic [10:0]    cx_q, cy_q;
	iter_t          cnt_q;
	logic [6:0]     iters_q;
	logic [3:0]     rr_q, cc_q;

	// window center from the current point (round half up)
	logic [10:0] cx_c, cy_c;
	logic        win_bad;
	assign cx_c = 11'((px_q[COORD_W:0] + 19'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign cy_c = 11'((py_q[COORD_W:0] + 19'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign win_bad = (cx_c < 11'(WIN_HALF + 1)) || (cy_c < 11'(WIN_HALF + 1)) ||
	                 ({1'b0, cx_c} + 12'(SCAN_SPAN - WIN_HALF - 1) >= {1'b0, w_eff}) ||
	                 ({1'b0, cy_c} + 12'(SCAN_SPAN - WIN_HALF - 1) >= {1'b0, h_eff});

	// ---------------- gradient pipeline ----------------
	// s1: pixel returned from the store, raster position tag
	logic       vld_s1;
	logic [3:0] rr_s1, cc_s1;
	logic [7:0] line_q [LINE_LEN];

	logic                in_win;
	logic [3:0]          ii, jj;
	logic [2:0]          kx, ky;
	logic signed [4:0]   ox_c, oy_c;
	assign in_win = vld_s1 && (rr_s1 >= 4'd2) && (cc_s1 >= 4'd1) && (cc_s1 <= 4'(SCAN_LAST - 1));
	assign ii   = rr_s1 - 4'd2;
	assign jj   = cc_s1 - 4'd1;
	assign kx   = (jj < 4'(WIN_HALF)) ? 3'(4'(WIN_HALF) - jj) : 3'(jj - 4'(WIN_HALF));
	assign ky   = (ii < 4'(WIN_HALF)) ? 3'(4'(WIN_HALF) - ii) : 3'(ii - 4'(WIN_HALF));
	assign ox_c = $signed({1'b0, jj}) - 5'sd5;
	assign oy_c = $signed({1'b0, ii}) - 5'sd5;

	// s2: gradients and raw weight product
	logic                vld_s2;
	logic signed [8:0]   gx_s2, gy_s2;
	logic [33:0]         wp_s2;
	logic signed [4:0]   ox_s2, oy_s2;
	// s3: saturated weight and gradient products
	logic                vld_s3;
	logic [15:0]         w_s3;
	logic signed [17:0]  gxx_s3, gxy_s3, gyy_s3;
	logic signed [4:0]   ox_s3, oy_s3;
	// s4: weighted products
	logic                vld_s4;
	logic signed [34:0]  pxx_s4, pxy_s4, pyy_s4;
	logic signed [4:0]   ox_s4, oy_s4;
	// s5: offset-weighted terms
	logic                vld_s5;
	logic signed [34:0]  pxx_s5, pxy_s5, pyy_s5;
	logic signed [ACC_W-1:0] t1_s5, t2_s5;

	logic [33:0] wr_c;
	assign wr_c = wp_s2 + 34'(1 << 15);

	logic signed [ACC_W-1:0] acc_q [5];
	logic pipe_busy;
	assign pipe_busy = vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			vld_s2 <= in_win;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		rr_s1 <= rr_q;
		cc_s1 <= cc_q;
		if (vld_s1) begin
			line_q[0] <= rdata_q;
			for (int k = 1; k < LINE_LEN; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
		// newest pixel is (r+1, q); taps reach (r, q+1), (r, q-1), (r-1, q)
		gx_s2 <= $signed({1'b0, line_q[SCAN_SPAN - 2]}) - $signed({1'b0, line_q[SCAN_SPAN]});
		gy_s2 <= $signed({1'b0, rdata_q}) - $signed({1'b0, line_q[LINE_LEN - 1]});
		wp_s2 <= 34'(AXIS_WEIGHT[kx]) * 34'(AXIS_WEIGHT[ky]);
		ox_s2 <= ox_c;
		oy_s2 <= oy_c;

		w_s3   <= (wr_c[33:16] > 18'd65535) ? 16'hFFFF : wr_c[31:16];
		gxx_s3 <= 18'(gx_s2) * 18'(gx_s2);
		gxy_s3 <= 18'(gx_s2) * 18'(gy_s2);
		gyy_s3 <= 18'(gy_s2) * 18'(gy_s2);
		ox_s3  <= ox_s2;
		oy_s3  <= oy_s2;

		pxx_s4 <= 35'(gxx_s3) * 35'($signed({1'b0, w_s3}));
		pxy_s4 <= 35'(gxy_s3) * 35'($signed({1'b0, w_s3}));
		pyy_s4 <= 35'(gyy_s3) * 35'($signed({1'b0, w_s3}));
		ox_s4  <= ox_s3;
		oy_s4  <= oy_s3;

		pxx_s5 <= pxx_s4;
		pxy_s5 <= pxy_s4;
		pyy_s5 <= pyy_s4;
		t1_s5  <= ACC_W'(pxx_s4) * ACC_W'(ox_s4) + ACC_W'(pxy_s4) * ACC_W'(oy_s4);
		t2_s5  <= ACC_W'(pxy_s4) * ACC_W'(ox_s4) + ACC_W'(pyy_s4) * ACC_W'(oy_s4);

		if (state_q == ST_CHECK) begin
			for (int k = 0; k < 5; k++) begin
				acc_q[k] <= '0;
			end
		end else if (vld_s5) begin
			acc_q[K_A]  <= acc_q[K_A]  + ACC_W'(pxx_s5);
			acc_q[K_B]  <= acc_q[K_B]  + ACC_W'(pxy_s5);
			acc_q[K_C]  <= acc_q[K_C]  + ACC_W'(pyy_s5);
			acc_q[K_B1] <= acc_q[K_B1] + t1_s5;
			acc_q[K_B2] <= acc_q[K_B2] + t2_s5;
		end
	end

	// ---------------- normalize and solve ----------------
	logic [ACC_W-1:0]        mag_q [5];
	logic                    neg_q [5];
	logic signed [NV_W-1:0]  nv [5];
	logic                    any_big;

	always_comb begin
		any_big = 1'b0;
		for (int k = 0; k < 5; k++) begin
			any_big = any_big || (mag_q[k][ACC_W-1:NORM_BITS] != '0);
			nv[k]   = neg_q[k] ? -$signed(NV_W'(mag_q[k])) : $signed(NV_W'(mag_q[k]));
		end
	end

	logic signed [SOL_W-1:0] p_ac_q, p_bb_q, p_cb1_q, p_bb2_q, p_ab2_q, p_bb1_q;
	logic signed [SOL_W-1:0] det_q, numx_q, numy_q;
	logic                    div_sel_q;

	// shared restoring divider on magnitudes
	logic [NUM_W-1:0] qt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic             qneg_q;
	logic [5:0]       div_cnt_q;
	logic [DEN_W:0]   trial;
	logic             trial_ge;
	logic signed [SOL_W-1:0] num_sel;
	logic [SOL_W-1:0]        num_mag;
	logic [NORM_BITS:0]      q_clamp;
	logic signed [NV_W-1:0]  move_c;
	logic signed [NV_W-1:0]  dx_q;

	assign trial    = {rem_q, qt_q[NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});
	assign num_sel  = div_sel_q ? numy_q : numx_q;
	assign num_mag  = num_sel[SOL_W-1] ? SOL_W'(-num_sel) : SOL_W'(num_sel);
	assign q_clamp  = (qt_q > NUM_W'(1 << MOVE_BITS)) ? (NORM_BITS+1)'(1 << MOVE_BITS)
	                                                   : (NORM_BITS+1)'(qt_q);
	assign move_c   = qneg_q ? -$signed(NV_W'(q_clamp)) : $signed(NV_W'(q_clamp));

	// position update
	logic signed [PW-1:0] nx_c, ny_c;
	logic signed [PW-1:0] ex_q, ey_q;
	logic [2*PW-1:0]      sqx_q, sqy_q;
	logic [2*PW:0]        err_c;
	logic                 stop_c;
	assign nx_c  = $signed(PW'({cx_q, FRAC_BITS'(0)})) + PW'(dx_q);
	assign ny_c  = $signed(PW'({cy_q, FRAC_BITS'(0)})) + PW'(move_c);
	assign err_c = (2*PW+1)'(sqx_q) + (2*PW+1)'(sqy_q);
	assign stop_c = px_q[PW-1] || py_q[PW-1] ||
	                (px_q >= $signed(PW'({w_eff, FRAC_BITS'(0)}))) ||
	                (py_q >= $signed(PW'({h_eff, FRAC_BITS'(0)}))) ||
	                (err_c <= (2*PW+1)'(eps_sq_q)) ||
	                (cnt_q >= iters_q);

	// final move check against the start point
	logic signed [PW:0] dfx, dfy;
	logic               too_far;
	assign dfx = (PW+1)'(px_q) - $signed((PW+1)'(sx_q));
	assign dfy = (PW+1)'(py_q) - $signed((PW+1)'(sy_q));
	assign too_far = (dfx > (PW+1)'(WIN_HALF << FRAC_BITS)) || (dfx < -(PW+1)'(WIN_HALF << FRAC_BITS)) ||
	                 (dfy > (PW+1)'(WIN_HALF << FRAC_BITS)) || (dfy < -(PW+1)'(WIN_HALF << FRAC_BITS));

	logic [47:0] out_q;
	logic        out_vld_q;
	logic        out_load;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	// result register frees as the previous transaction drains
	assign out_load = (state_q == ST_FINAL) && (!out_vld_q || m_tready);

	// payload of the solve path
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DRAIN: begin
				for (int k = 0; k < 5; k++) begin
					neg_q[k] <= acc_q[k][ACC_W-1];
					mag_q[k] <= acc_q[k][ACC_W-1] ? ACC_W'(-acc_q[k]) : ACC_W'(acc_q[k]);
				end
			end
			ST_NORM: begin
				if (any_big) begin
					for (int k = 0; k < 5; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end
			end
			ST_PROD: begin
				p_ac_q  <= SOL_W'(nv[K_A]) * SOL_W'(nv[K_C]);
				p_bb_q  <= SOL_W'(nv[K_B]) * SOL_W'(nv[K_B]);
				p_cb1_q <= SOL_W'(nv[K_C]) * SOL_W'(nv[K_B1]);
				p_bb2_q <= SOL_W'(nv[K_B]) * SOL_W'(nv[K_B2]);
				p_ab2_q <= SOL_W'(nv[K_A]) * SOL_W'(nv[K_B2]);
				p_bb1_q <= SOL_W'(nv[K_B]) * SOL_W'(nv[K_B1]);
			end
			ST_DIFF: begin
				det_q  <= p_ac_q - p_bb_q;
				numx_q <= p_cb1_q - p_bb2_q;
				numy_q <= p_ab2_q - p_bb1_q;
			end
			ST_DIV_INIT: begin
				qt_q   <= {num_mag[SOL_W-2:0], FRAC_BITS'(0)};
				rem_q  <= '0;
				den_q  <= det_q[SOL_W-1] ? DEN_W'(-det_q) : DEN_W'(det_q);
				qneg_q <= num_sel[SOL_W-1] ^ det_q[SOL_W-1];
			end
			ST_DIV_RUN: begin
				rem_q <= trial_ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
				qt_q  <= {qt_q[NUM_W-2:0], trial_ge};
			end
			ST_DIV_DONE: begin
				if (!div_sel_q) begin
					dx_q <= move_c;
				end
			end
			ST_UPDATE: begin
				ex_q <= nx_c - px_q;
				ey_q <= ny_c - py_q;
			end
			ST_SQUARE: begin
				sqx_q <= (2*PW)'(ex_q * ex_q);
				sqy_q <= (2*PW)'(ey_q * ey_q);
			end
			default: begin
			end
		endcase
	end

	// control, config and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			max_iters_q    <= 7'd100;
			eps_sq_q       <= 16'd0;
			image_width_q  <= 11'd640;
			image_height_q <= 11'd480;
			out_vld_q      <= 1'b0;
			out_q          <= '0;
			sx_q           <= '0;
			sy_q           <= '0;
			px_q           <= '0;
			py_q           <= '0;
			cx_q           <= '0;
			cy_q           <= '0;
			cnt_q          <= '0;
			iters_q        <= 7'd1;
			rr_q           <= '0;
			cc_q           <= '0;
			rd_addr_q      <= '0;
			div_sel_q      <= 1'b0;
			div_cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_ITERS:    max_iters_q    <= cfg_data[6:0];
					REG_EPS_SQ:       eps_sq_q       <= cfg_data;
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[10:0];
					REG_IMAGE_HEIGHT: image_height_q <= cfg_data[10:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_fire && (s_tuser == CMD_REFINE)) begin
						sx_q    <= in_sx;
						sy_q    <= in_sy;
						px_q    <= PW'(in_sx);
						py_q    <= PW'(in_sy);
						cnt_q   <= '0;
						iters_q <= (max_iters_q == 7'd0) ? 7'd1 :
						           (max_iters_q > 7'(ITER_CAP)) ? 7'(ITER_CAP) : max_iters_q;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cx_q <= cx_c;
					cy_q <= cy_c;
					rr_q <= '0;
					cc_q <= '0;
					rd_addr_q <= AW'(cy_c - 11'(WIN_HALF + 1)) * AW'(IMG_WIDTH) +
					             AW'(cx_c - 11'(WIN_HALF + 1));
					state_q <= win_bad ? ST_FINAL : ST_SCAN;
				end
				ST_SCAN: begin
					// one store read per cycle, raster over the bordered window
					if (cc_q == 4'(SCAN_LAST)) begin
						cc_q      <= '0;
						rr_q      <= rr_q + 4'd1;
						rd_addr_q <= rd_addr_q + AW'(IMG_WIDTH - SCAN_LAST);
						if (rr_q == 4'(SCAN_LAST)) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						cc_q      <= cc_q + 4'd1;
						rd_addr_q <= rd_addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (!any_big) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					div_sel_q <= 1'b0;
					state_q   <= ST_DIV_INIT;
				end
				ST_DIV_INIT: begin
					div_cnt_q <= 6'(NUM_W - 1);
					state_q   <= (det_q == '0) ? ST_FINAL : ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					div_cnt_q <= div_cnt_q - 6'd1;
					if (div_cnt_q == '0) begin
						state_q <= ST_DIV_DONE;
					end
				end
				ST_DIV_DONE: begin
					if (!div_sel_q) begin
						div_sel_q <= 1'b1;
						state_q   <= ST_DIV_INIT;
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					px_q    <= nx_c;
					py_q    <= ny_c;
					cnt_q   <= cnt_q + 7'd1;
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					state_q <= stop_c ? ST_FINAL : ST_CHECK;
				end
				ST_FINAL: begin
					if (out_load) begin
						out_q     <= {5'b0, cnt_q,
						              too_far ? sy_q : py_q[COORD_W-1:0],
						              too_far ? sx_q : px_q[COORD_W-1:0]};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
